// ----- hw/rtl/subset_enumerator_by_size_top_defines.svh -----
// ----------------------------------------------------------------------------
// Subset enumerator assertion macros
// Shared property forms for the checks in the enumerator RTL.
// ----------------------------------------------------------------------------
`ifndef SUBSET_ENUMERATOR_BY_SIZE_TOP_DEFINES_SVH
`define SUBSET_ENUMERATOR_BY_SIZE_TOP_DEFINES_SVH

// condition holds at every clock edge out of reset
`define SEBS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SEBS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SEBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/sebs_pkg.sv -----
// ----------------------------------------------------------------------------
// Subset enumerator package
// Transfer types, widths, command codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package sebs_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int VTX_W            = 64;
  localparam int CNT_W            = 7;

  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_NEXT    = 1'b1;

  typedef struct packed {
    logic             command;
    logic [CNT_W-1:0] bound;
  } sebs_in_t;

  typedef struct packed {
    logic             found;
    logic [VTX_W-1:0] subset_mask;
    logic [CNT_W-1:0] subset_size;
  } sebs_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BUILD,
    ST_ADV,
    ST_FILL,
    ST_DONE
  } sebs_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sebs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sebs_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/subset_enumerator_by_size_top.sv -----
// ----------------------------------------------------------------------------
// Subset enumerator by size
// A restart (command 0) packs the members of the vertex mask into a position
// table and begins at size 1, one mask bit per cycle. A next request
// (command 1) either answers not-found or delivers the current subset of
// size k and advances to the next combination. Slot indices live in a
// single-port-per-direction RAM that is walked one entry per cycle: the mask
// is built, then the advance scan runs, then the trailing slots are refilled
// where needed.
// One item is in work at a time; the result sits in an output register so the
// next item may be accepted while it waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "subset_enumerator_by_size_top_defines.svh"

module subset_enumerator_by_size_top #(
  parameter int MAX_VERTICES = sebs_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [sebs_pkg::VTX_W-1:0]      cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire sebs_pkg::sebs_in_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output sebs_pkg::sebs_out_t                  out_data
);

  localparam int IW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = sebs_pkg::CNT_W;
  localparam int VTX_W = sebs_pkg::VTX_W;

  sebs_pkg::sebs_state_t state_r, state_nxt;

  logic [VTX_W-1:0]        vmask_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        size_r, size_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic                    on_r, on_nxt;
  logic                    p1_r, p1_nxt;
  logic                    p2_r, p2_nxt;
  logic [VTX_W-1:0]        acc_r, acc_nxt;
  logic [IW-1:0]           w_r, w_nxt;
  sebs_pkg::sebs_out_t     res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  sebs_pkg::sebs_out_t     out_data_r, out_data_nxt;
  logic [MAX_VERTICES-1:0] slot_vld_r, slot_vld_nxt;
  logic [IW-1:0]           slot_raddr_r;

  logic                    slot_we;
  logic [IW-1:0]           slot_waddr, slot_wdata, slot_raddr, slot_rdata, slot_val;
  logic                    pos_we;
  logic [IW-1:0]           pos_waddr, pos_wdata, pos_raddr, pos_rdata;

  logic                    in_fire, no_req, bld_done, adv_hit, adv_exh;
  logic                    hit_last, fill_last, scan_last, out_free;
  logic [CNT_W-1:0]        size_m1, lim;
  logic [IW-1:0]           k_m1, slot_inc;
  logic [VTX_W-1:0]        acc_new;

  sebs_ram #(.WIDTH(IW), .DEPTH(MAX_VERTICES)) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (slot_waddr),
    .wr_data (slot_wdata),
    .rd_addr (slot_raddr),
    .rd_data (slot_rdata)
  );

  sebs_ram #(.WIDTH(IW), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk     (clk),
    .wr_en   (pos_we),
    .wr_addr (pos_waddr),
    .wr_data (pos_wdata),
    .rd_addr (pos_raddr),
    .rd_data (pos_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != sebs_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign slot_val  = slot_vld_r[slot_raddr_r] ? slot_rdata : slot_raddr_r;
  assign slot_inc  = slot_val + IW'(1);
  assign size_m1   = size_r - CNT_W'(1);
  assign k_m1      = size_m1[IW-1:0];
  assign no_req    = (in_data.bound < size_r) || (size_r > count_r);
  assign bld_done  = !on_r && !p1_r && p2_r;
  assign acc_new   = acc_r | (p2_r ? (VTX_W'(1) << pos_rdata) : '0);
  assign lim       = count_r - size_r + CNT_W'(slot_raddr_r);
  assign adv_hit   = p1_r && (CNT_W'(slot_val) < lim);
  assign adv_exh   = p1_r && !adv_hit && (slot_raddr_r == '0);
  assign hit_last  = (slot_raddr_r == k_m1);
  assign fill_last = (idx_r == k_m1);
  assign scan_last = (idx_r == IW'(MAX_VERTICES - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sebs_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_data.command == sebs_pkg::CMD_RESTART) begin
            state_nxt = sebs_pkg::ST_SCAN;
          end else if (no_req) begin
            state_nxt = sebs_pkg::ST_DONE;
          end else begin
            state_nxt = sebs_pkg::ST_BUILD;
          end
        end
      end
      sebs_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = sebs_pkg::ST_DONE;
        end
      end
      sebs_pkg::ST_BUILD: begin
        if (bld_done) begin
          state_nxt = sebs_pkg::ST_ADV;
        end
      end
      sebs_pkg::ST_ADV: begin
        if (adv_hit) begin
          state_nxt = hit_last ? sebs_pkg::ST_DONE : sebs_pkg::ST_FILL;
        end else if (adv_exh) begin
          state_nxt = sebs_pkg::ST_DONE;
        end
      end
      sebs_pkg::ST_FILL: begin
        if (fill_last) begin
          state_nxt = sebs_pkg::ST_DONE;
        end
      end
      sebs_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = sebs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sebs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    size_nxt      = size_r;
    idx_nxt       = idx_r;
    on_nxt        = on_r;
    p1_nxt        = 1'b0;
    p2_nxt        = 1'b0;
    acc_nxt       = acc_r;
    w_nxt         = w_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    slot_vld_nxt  = slot_vld_r;
    slot_raddr    = idx_r;
    slot_we       = 1'b0;
    slot_waddr    = idx_r;
    slot_wdata    = slot_inc;
    pos_we        = 1'b0;
    pos_waddr     = count_r[IW-1:0];
    pos_wdata     = idx_r;
    pos_raddr     = slot_val;

    unique case (state_r)
      sebs_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_nxt = '0;
          idx_nxt = '0;
          acc_nxt = '0;
          on_nxt  = 1'b1;
          if (in_data.command == sebs_pkg::CMD_RESTART) begin
            count_nxt = '0;
          end
        end
      end
      sebs_pkg::ST_SCAN: begin
        if (vmask_r[idx_r]) begin
          pos_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
        if (scan_last) begin
          size_nxt     = CNT_W'(1);
          slot_vld_nxt = '0;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      sebs_pkg::ST_BUILD: begin
        p1_nxt  = on_r;
        p2_nxt  = p1_r;
        acc_nxt = acc_new;
        if (on_r) begin
          if (idx_r == k_m1) begin
            on_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
        if (bld_done) begin
          res_nxt.found       = 1'b1;
          res_nxt.subset_mask = acc_new;
          res_nxt.subset_size = size_r;
          idx_nxt             = k_m1;
          on_nxt              = 1'b1;
          p1_nxt              = 1'b0;
          p2_nxt              = 1'b0;
        end
      end
      sebs_pkg::ST_ADV: begin
        p1_nxt = on_r;
        if (on_r) begin
          if (idx_r == '0) begin
            on_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r - IW'(1);
          end
        end
        if (adv_hit) begin
          slot_we    = 1'b1;
          slot_waddr = slot_raddr_r;
          slot_wdata = slot_inc;
          w_nxt      = slot_inc;
          idx_nxt    = slot_raddr_r + IW'(1);
          on_nxt     = 1'b0;
          p1_nxt     = 1'b0;
        end else if (adv_exh) begin
          size_nxt     = size_r + CNT_W'(1);
          slot_vld_nxt = '0;
          on_nxt       = 1'b0;
          p1_nxt       = 1'b0;
        end
      end
      sebs_pkg::ST_FILL: begin
        slot_we    = 1'b1;
        slot_waddr = idx_r;
        slot_wdata = w_r + IW'(1);
        w_nxt      = w_r + IW'(1);
        if (!fill_last) begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      sebs_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: begin
        on_nxt = 1'b0;
      end
    endcase

    if (slot_we) begin
      slot_vld_nxt[slot_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sebs_pkg::ST_IDLE;
      vmask_r     <= '0;
      count_r     <= '0;
      size_r      <= CNT_W'(1);
      on_r        <= 1'b0;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      slot_vld_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        vmask_r <= cfg_data;
      end
      count_r     <= count_nxt;
      size_r      <= size_nxt;
      on_r        <= on_nxt;
      p1_r        <= p1_nxt;
      p2_r        <= p2_nxt;
      out_valid_r <= out_valid_nxt;
      slot_vld_r  <= slot_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    acc_r        <= acc_nxt;
    w_r          <= w_nxt;
    res_r        <= res_nxt;
    out_data_r   <= out_data_nxt;
    slot_raddr_r <= slot_raddr;
  end

  `SEBS_ASSERT_IMPL(a_found_size, out_valid_r && out_data_r.found, $countones(out_data_r.subset_mask) == int'(out_data_r.subset_size), "subset mask population differs from subset size")
  `SEBS_ASSERT_IMPL(a_none_zero, out_valid_r && !out_data_r.found, (out_data_r.subset_mask == '0) && (out_data_r.subset_size == '0), "not-found result carries data")
  `SEBS_ASSERT_ALWAYS(a_size_range, (state_r == sebs_pkg::ST_SCAN) || (size_r <= count_r + CNT_W'(1)), "current size beyond member count plus one")
  `SEBS_ASSERT_NEXT(a_busy_after_accept, in_fire, in_stall, "input not stalled after a transfer")

endmodule

`default_nettype wire
